// File: hdl/stt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the sparse triplet transpose unit: request and
// result payloads, stored term layout and the microcode control word.
// ---------------------------------------------------------------------------
package stt_pkg;

	localparam int DIM_W = 11;
	localparam int VAL_W = 32;

	// header row and column counts saturate here
	localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

	typedef enum logic {
		CMD_HEADER = 1'b0,
		CMD_TERM   = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [DIM_W-1:0]        in_row;
		logic [DIM_W-1:0]        in_col;
		logic signed [VAL_W-1:0] in_value;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0]        out_row;
		logic [DIM_W-1:0]        out_col;
		logic signed [VAL_W-1:0] out_value;
		logic                    out_last;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [VAL_W-1:0] value;
	} term_t;

	// microprogram step addresses
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT_INIT,
		ST_CNT_RD,
		ST_CNT_EV,
		ST_HDR,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_PASS_NEXT
	} step_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		RM_HOLD,
		RM_CLR,
		RM_COUNT,
		RM_EMIT
	} rem_op_t;

	typedef enum logic [1:0] {
		NX_HOLD,
		NX_INIT,
		NX_MIN_ALL,
		NX_MIN_ABOVE
	} nx_op_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_HDR,
		EM_TERM
	} emit_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_LOAD_DONE,
		CND_IDX_END,
		CND_REMAIN_ZERO,
		CND_LAST
	} cond_t;

	typedef struct packed {
		logic    accept;
		idx_op_t idx_op;
		rem_op_t rem_op;
		nx_op_t  nx_op;
		logic    adv_col;
		logic    rd_en;
		emit_t   emit;
		cond_t   cond;
		step_t   t_true;
		step_t   t_false;
	} ctrl_t;

endpackage

`default_nettype wire

// File: hdl/stt_ucode_rom.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stt_ucode_rom
// Microprogram store: one control word per step, with a taken and a
// not-taken successor for the step's jump condition.
// ---------------------------------------------------------------------------
module stt_ucode_rom
	import stt_pkg::*;
(
	input  step_t step,
	output ctrl_t ctrl
);

	always_comb begin
		ctrl = '{accept: 1'b0, idx_op: IDX_HOLD, rem_op: RM_HOLD, nx_op: NX_HOLD,
			adv_col: 1'b0, rd_en: 1'b0, emit: EM_NONE, cond: CND_ALWAYS,
			t_true: ST_IDLE, t_false: ST_IDLE};
		unique case (step)
			ST_IDLE: begin
				ctrl.accept  = 1'b1;
				ctrl.cond    = CND_LOAD_DONE;
				ctrl.t_true  = ST_CNT_INIT;
				ctrl.t_false = ST_IDLE;
			end
			ST_CNT_INIT: begin
				ctrl.idx_op  = IDX_CLR;
				ctrl.rem_op  = RM_CLR;
				ctrl.nx_op   = NX_INIT;
				ctrl.t_true  = ST_CNT_RD;
			end
			// counting pass: in-range terms and the lowest column among them
			ST_CNT_RD: begin
				ctrl.rd_en   = 1'b1;
				ctrl.cond    = CND_IDX_END;
				ctrl.t_true  = ST_HDR;
				ctrl.t_false = ST_CNT_EV;
			end
			ST_CNT_EV: begin
				ctrl.idx_op  = IDX_INC;
				ctrl.rem_op  = RM_COUNT;
				ctrl.nx_op   = NX_MIN_ALL;
				ctrl.t_true  = ST_CNT_RD;
			end
			ST_HDR: begin
				ctrl.emit    = EM_HDR;
				ctrl.adv_col = 1'b1;
				ctrl.nx_op   = NX_INIT;
				ctrl.idx_op  = IDX_CLR;
				ctrl.cond    = CND_REMAIN_ZERO;
				ctrl.t_true  = ST_IDLE;
				ctrl.t_false = ST_SCAN_RD;
			end
			// one pass per occupied column
			ST_SCAN_RD: begin
				ctrl.rd_en   = 1'b1;
				ctrl.cond    = CND_IDX_END;
				ctrl.t_true  = ST_PASS_NEXT;
				ctrl.t_false = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				ctrl.emit    = EM_TERM;
				ctrl.idx_op  = IDX_INC;
				ctrl.rem_op  = RM_EMIT;
				ctrl.nx_op   = NX_MIN_ABOVE;
				ctrl.cond    = CND_LAST;
				ctrl.t_true  = ST_IDLE;
				ctrl.t_false = ST_SCAN_RD;
			end
			ST_PASS_NEXT: begin
				ctrl.adv_col = 1'b1;
				ctrl.nx_op   = NX_INIT;
				ctrl.idx_op  = IDX_CLR;
				ctrl.t_true  = ST_SCAN_RD;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/stt_term_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stt_term_mem
// Term store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module stt_term_mem
	import stt_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  term_t              wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output term_t              rd_data
);

	term_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/sparse_triplet_transpose_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sparse_triplet_transpose_unit
// Transposes a sparse matrix given as a header request and a list of
// (row, column, value) term requests, driven by a small microprogram.
// ---------------------------------------------------------------------------
// A header request (cmd 0) starts a load; term requests are then taken one per
// cycle and written to the term store. When the announced count is reached
// (at once for a count of zero) the request side stalls while the sequencer
// emits the swapped header and the swapped terms, ordered by source column
// and in arrival order within a column; terms whose column is not below the
// column count are dropped. Emission runs a counting pass over the store,
// then the header, then one pass for each distinct in-range column that
// holds terms (the last pass ends at its final term); each term is read
// through the single registered read port of the store and every pass
// walks the whole store. Output back pressure stalls the sequencer.
// ---------------------------------------------------------------------------
module sparse_triplet_transpose_unit
	import stt_pkg::*;
#(
	parameter int MAX_TERMS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	input  item_t     item,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic [VAL_W-1:0] TERM_CAP = VAL_W'(MAX_TERMS);

	step_t step_q, step_d;
	ctrl_t cw;

	logic [DIM_W-1:0] row_cnt_q, col_cnt_q;
	logic [CW-1:0]    term_cnt_q, loaded_q, idx_q, remain_q;
	logic [DIM_W-1:0] cur_col_q, next_col_q;
	result_t          result_q;
	logic             result_valid_q;

	term_t            rd_data;
	logic             accept, is_header, term_take, load_done;
	logic [CW-1:0]    hdr_cnt;
	logic [DIM_W-1:0] hdr_rows, hdr_cols;
	logic             match, in_range, emit_req, hold, cond_ok, out_load, last_emit;
	result_t          result_d;

	stt_ucode_rom u_rom (
		.step (step_q),
		.ctrl (cw)
	);

	stt_term_mem #(
		.DEPTH (MAX_TERMS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (term_take),
		.wr_addr (loaded_q[AW-1:0]),
		.wr_data ('{row: item.in_row, col: item.in_col, value: item.in_value}),
		.rd_en   (cw.rd_en && (idx_q != loaded_q)),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// request side
	assign item_stall = !cw.accept;
	assign accept     = item_valid && cw.accept;
	assign is_header  = (item.cmd == CMD_HEADER);
	assign term_take  = accept && !is_header && (loaded_q < term_cnt_q);

	always_comb begin
		hdr_rows = (item.in_row > MAX_DIM) ? MAX_DIM : item.in_row;
		hdr_cols = (item.in_col > MAX_DIM) ? MAX_DIM : item.in_col;
		if (item.in_value[VAL_W-1]) begin
			hdr_cnt = '0;
		end else if (VAL_W'(item.in_value) > TERM_CAP) begin
			hdr_cnt = CW'(MAX_TERMS);
		end else begin
			hdr_cnt = item.in_value[CW-1:0];
		end
	end

	assign load_done = accept && (is_header ? (hdr_cnt == '0)
		: (term_take && ((loaded_q + CW'(1)) == term_cnt_q)));

	// scan datapath
	assign match     = (rd_data.col == cur_col_q);
	assign in_range  = (rd_data.col < col_cnt_q);
	assign emit_req  = (cw.emit == EM_HDR) || ((cw.emit == EM_TERM) && match);
	assign hold      = emit_req && result_valid_q && result_stall;
	assign out_load  = emit_req && !hold;
	assign last_emit = match && (remain_q == CW'(1));

	always_comb begin
		unique case (cw.cond)
			CND_ALWAYS:      cond_ok = 1'b1;
			CND_LOAD_DONE:   cond_ok = load_done;
			CND_IDX_END:     cond_ok = (idx_q == loaded_q);
			CND_REMAIN_ZERO: cond_ok = (remain_q == '0);
			CND_LAST:        cond_ok = last_emit;
			default:         cond_ok = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else begin
			step_d = cond_ok ? cw.t_true : cw.t_false;
		end
	end

	always_comb begin
		if (cw.emit == EM_HDR) begin
			result_d.out_row   = col_cnt_q;
			result_d.out_col   = row_cnt_q;
			result_d.out_value = VAL_W'(term_cnt_q);
			result_d.out_last  = (remain_q == '0);
		end else begin
			result_d.out_row   = rd_data.col;
			result_d.out_col   = rd_data.row;
			result_d.out_value = rd_data.value;
			result_d.out_last  = last_emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= '0;
			col_cnt_q  <= '0;
			term_cnt_q <= '0;
			loaded_q   <= '0;
		end else if (accept) begin
			if (is_header) begin
				row_cnt_q  <= hdr_rows;
				col_cnt_q  <= hdr_cols;
				term_cnt_q <= hdr_cnt;
				loaded_q   <= '0;
			end else if (term_take) begin
				loaded_q <= loaded_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			remain_q   <= '0;
			cur_col_q  <= '0;
			next_col_q <= '0;
		end else if (!hold) begin
			unique case (cw.idx_op)
				IDX_CLR:  idx_q <= '0;
				IDX_INC:  idx_q <= idx_q + CW'(1);
				default:  idx_q <= idx_q;
			endcase
			unique case (cw.rem_op)
				RM_CLR:   remain_q <= '0;
				RM_COUNT: if (in_range) begin
					remain_q <= remain_q + CW'(1);
				end
				RM_EMIT:  if (match) begin
					remain_q <= remain_q - CW'(1);
				end
				default:  remain_q <= remain_q;
			endcase
			if (cw.adv_col) begin
				cur_col_q <= next_col_q;
			end
			// lowest in-range column seen, strictly above the current one when scanning
			unique case (cw.nx_op)
				NX_INIT: next_col_q <= col_cnt_q;
				NX_MIN_ALL: if (in_range && (rd_data.col < next_col_q)) begin
					next_col_q <= rd_data.col;
				end
				NX_MIN_ABOVE: if (in_range && (rd_data.col > cur_col_q)
						&& (rd_data.col < next_col_q)) begin
					next_col_q <= rd_data.col;
				end
				default: next_col_q <= next_col_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= term_cnt_q)
		else $error("loaded terms exceed announced count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		term_cnt_q <= CW'(MAX_TERMS))
		else $error("term count above capacity");

	a_scan_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_SCAN_RD || step_q == ST_SCAN_EV || step_q == ST_PASS_NEXT)
		|-> (remain_q != '0))
		else $error("column scan running with nothing left to emit");

	a_scan_col: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_SCAN_RD || step_q == ST_SCAN_EV) |-> (cur_col_q < col_cnt_q))
		else $error("scan column out of range");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && result_d.out_last) |=> (step_q == ST_IDLE))
		else $error("sequencer did not return to idle after final result");

endmodule

`default_nettype wire

// File: sim/tb_sparse_triplet_transpose_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sparse_triplet_transpose_unit
// Self-checking bench for the sparse triplet transpose unit. A queue of header
// and term requests feeds a bursty driver, and the receiver stalls on its own
// pattern, including one long hold-off. Each accepted request goes through a
// transpose predictor, and every result is checked against the oldest
// predicted one.
// ---------------------------------------------------------------------------
module tb_sparse_triplet_transpose_unit;
	import stt_pkg::*;

	localparam int MAX_TERMS    = 32;
	localparam int RANDOM_ITEMS = 400;
	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 200;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	item_t   pending_requests[$];
	result_t expected_results[$];

	// transpose predictor state
	logic [DIM_W-1:0] src_rows = '0;
	logic [DIM_W-1:0] src_cols = '0;
	int unsigned      announced = 0;
	int unsigned      stored = 0;
	logic [DIM_W-1:0] term_row[MAX_TERMS];
	logic [DIM_W-1:0] term_col[MAX_TERMS];
	logic [VAL_W-1:0] term_val[MAX_TERMS];

	int  cycles = 0;
	int  requests_taken = 0;
	int  request_total = 0;
	int  mismatches = 0;
	int  taken_seen = 0;
	bit  hold_off = 1'b0;
	int  burst_left = 1;
	int  gap_left = 0;
	int  stall_mode = 0;
	int  mode_left = 0;
	int  stall_phase = 0;

	sparse_triplet_transpose_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned clamp_count(logic signed [VAL_W-1:0] v);
		if (v < 0)
			return 0;
		if (v > MAX_TERMS)
			return MAX_TERMS;
		return v;
	endfunction

	task automatic emit_transposed();
		result_t r;
		r.out_row   = src_cols;
		r.out_col   = src_rows;
		r.out_value = announced;
		r.out_last  = 1'b0;
		expected_results.push_back(r);
		for (int c = 0; c < src_cols; c++) begin
			for (int j = 0; j < stored; j++) begin
				if (term_col[j] == c) begin
					r.out_row   = term_col[j];
					r.out_col   = term_row[j];
					r.out_value = term_val[j];
					r.out_last  = 1'b0;
					expected_results.push_back(r);
				end
			end
		end
		expected_results[expected_results.size()-1].out_last = 1'b1;
	endtask

	task automatic apply_request(item_t it);
		if (it.cmd == CMD_HEADER) begin
			src_rows  = (it.in_row > MAX_DIM) ? MAX_DIM : it.in_row;
			src_cols  = (it.in_col > MAX_DIM) ? MAX_DIM : it.in_col;
			announced = clamp_count(it.in_value);
			stored    = 0;
			if (announced == 0)
				emit_transposed();
		end else if (stored < announced && stored < MAX_TERMS) begin
			term_row[stored] = it.in_row;
			term_col[stored] = it.in_col;
			term_val[stored] = it.in_value;
			stored++;
			if (stored == announced)
				emit_transposed();
		end
	endtask

	task automatic push_request(cmd_t c, logic [DIM_W-1:0] r, logic [DIM_W-1:0] col,
			logic [VAL_W-1:0] v);
		item_t it;
		it.cmd      = c;
		it.in_row   = r;
		it.in_col   = col;
		it.in_value = v;
		pending_requests.push_back(it);
	endtask

	// driver: bursts of requests with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || (requests_taken != taken_seen)) begin
			taken_seen = requests_taken;
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				item       <= pending_requests.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, switching mode now and then
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		stall_phase++;
		if (hold_off)
			result_stall <= 1'b1;
		else unique case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 1) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (stall_phase % 7 < 3);
		endcase
	end

	// monitor: request acceptance feeds the predictor, results are checked
	always @(posedge clk) begin
		result_t exp_r;
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			if (arst_n && item_valid && !item_stall) begin
				apply_request(item);
				requests_taken++;
			end
			if (arst_n && result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result row %0d col %0d value %0d last %0b",
							result.out_row, result.out_col, result.out_value,
							result.out_last);
				end else begin
					exp_r = expected_results.pop_front();
					if (result.out_row !== exp_r.out_row || result.out_col !== exp_r.out_col
							|| result.out_value !== exp_r.out_value
							|| result.out_last !== exp_r.out_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
								exp_r.out_row, exp_r.out_col, exp_r.out_value,
								exp_r.out_last, result.out_row, result.out_col,
								result.out_value, result.out_last);
					end
				end
			end
		end
	end

	// long receiver hold-off so the unit backs up into the request side
	initial begin
		while (requests_taken < 60)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int               loaded;
		int               pick;
		int               n;
		int               m;
		int               dim_cols;
		bit               load_open;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic [VAL_W-1:0] v;

		// directed: stray term with no load in progress is ignored
		push_request(CMD_TERM, 11'd3, 11'd4, 32'd99);
		// empty matrix, then negative count with oversized dimensions
		push_request(CMD_HEADER, 11'd5, 11'd7, 32'd0);
		push_request(CMD_HEADER, 11'd2047, 11'd2047, 32'h8000_0000);
		// only term out of range after column saturation: header alone
		push_request(CMD_HEADER, 11'd1024, 11'd1025, 32'd1);
		push_request(CMD_TERM, 11'd2047, 11'd1500, 32'h7fff_ffff);
		// zero columns drops every term
		push_request(CMD_HEADER, 11'd0, 11'd0, 32'd1);
		push_request(CMD_TERM, 11'd0, 11'd0, 32'd5);
		// column ordering, ties in arrival order, one term dropped
		push_request(CMD_HEADER, 11'd3, 11'd4, 32'd4);
		push_request(CMD_TERM, 11'd0, 11'd2, 32'h8000_0000);
		push_request(CMD_TERM, 11'd2047, 11'd0, 32'hffff_ffff);
		push_request(CMD_TERM, 11'd1, 11'd2, 32'h7fff_ffff);
		push_request(CMD_TERM, 11'd1024, 11'd1024, 32'd0);
		// extra term after the load completed is ignored
		push_request(CMD_TERM, 11'd5, 11'd5, 32'd5);
		// header mid-load restarts the load
		push_request(CMD_HEADER, 11'd6, 11'd6, 32'd3);
		push_request(CMD_TERM, 11'd1, 11'd1, 32'd1);
		push_request(CMD_HEADER, 11'd6, 11'd6, 32'd2);
		push_request(CMD_TERM, 11'd2, 11'd5, 32'd7);
		push_request(CMD_TERM, 11'd3, 11'd0, 32'd8);
		// top in-range column at full dimension
		push_request(CMD_HEADER, 11'd1024, 11'd1024, 32'd2);
		push_request(CMD_TERM, 11'd2047, 11'd1023, 32'h5555_5555);
		push_request(CMD_TERM, 11'd0, 11'd0, 32'haaaa_aaaa);

		loaded    = 0;
		load_open = 1'b0;
		while (loaded < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			rows = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(1, 16));
			if (pick < 6 && !load_open) begin
				push_request(CMD_TERM, DIM_W'($urandom_range(0, 2047)),
					DIM_W'($urandom_range(0, 2047)), $urandom);
				loaded += 1;
			end else if (pick < 18) begin
				// broken load: fewer terms than announced
				n = $urandom_range(2, 8);
				m = $urandom_range(0, n - 1);
				push_request(CMD_HEADER, rows, DIM_W'($urandom_range(1, 12)), VAL_W'(n));
				for (int i = 0; i < m; i++)
					push_request(CMD_TERM, DIM_W'($urandom_range(0, 2047)),
						DIM_W'($urandom_range(0, 12)), $urandom);
				loaded    += 1 + m;
				load_open = 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					cols = DIM_W'($urandom_range(1, 12));
				else if (pick < 85)
					cols = DIM_W'($urandom_range(0, 2047));
				else
					cols = MAX_DIM;
				pick = $urandom_range(0, 99);
				if (pick < 5)
					v = $urandom | 32'h8000_0000;
				else if (pick < 10)
					v = $urandom_range(33, 32'h7fff_ffff);
				else if (pick < 16)
					v = MAX_TERMS;
				else if (pick < 26)
					v = 0;
				else
					v = $urandom_range(1, 8);
				n        = clamp_count(v);
				dim_cols = (cols > MAX_DIM) ? MAX_DIM : cols;
				push_request(CMD_HEADER, rows, cols, v);
				for (int i = 0; i < n; i++) begin
					if (dim_cols == 0 || $urandom_range(0, 99) < 15)
						col = DIM_W'($urandom_range(0, 2047));
					else
						col = DIM_W'($urandom_range(0, dim_cols - 1));
					row = DIM_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047)
						: $urandom_range(0, 15));
					push_request(CMD_TERM, row, col, $urandom);
				end
				loaded    += 1 + n;
				load_open = 1'b0;
			end
		end
		request_total = pending_requests.size();

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		while (requests_taken != request_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sparse_triplet_transpose_unit.f
hdl/stt_pkg.sv
hdl/stt_ucode_rom.sv
hdl/stt_term_mem.sv
hdl/sparse_triplet_transpose_unit.sv
sim/tb_sparse_triplet_transpose_unit.sv
